### sv/olads_pkg.sv
// ----------------------------------------------------------------------------
// olads_pkg: shared types for the ordered list unit
// Request kinds, result status codes and the command and status groups
// that pass between the list controller and the list datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package olads_pkg;

    // Request kinds as carried on the kind field. Code 3 is unused.
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;       // latch the incoming request
        logic    append_wr;    // write the incoming value at the tail
        logic    scan_start;   // rewind the walk pointer to the head
        logic    scan_step;    // issue the next read of the walk
        logic    shift_step;   // move the entry just read one place forward
        logic    del_commit;   // one entry fewer at the end of a delete
        logic    res_we;       // capture a result status
        t_status res_status;
        logic    res_take_idx; // position is the index of the entry just compared
        logic    load_out;     // move the finished result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_kind;    // kind field of the request being offered
        logic       is_delete;  // latched request is a delete
        logic       list_empty;
        logic       list_full;
        logic       hit;        // entry just read equals the requested value
        logic       miss_end;   // last entry read and it does not match
        logic       shift_end;  // no entries left to read during the shift
        logic       out_free;   // output register can take a result now
    } t_stat;

endpackage

`default_nettype wire

### sv/ordered_list_append_delete_search_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_append_delete_search_unit: ordered list of 32-bit values
// Keeps up to CAPACITY signed values in insertion order. Append adds at the
// tail, delete removes the first match and closes the gap, search reports
// the index of the first match. Every request returns one result.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   request   in         i_valid / o_ready  i_kind, i_value
//   result    out        o_valid / i_ready  o_status, o_position, o_entry_count
//
// An append, a refused request or one on an empty list skips the walk; a
// search walks the entries up to the first match, and a delete walks to the
// match and then shifts the later entries one place forward:
// the single read port visits one entry per cycle in the walk and the shift.
// Reset clears the count; the entry memory needs no clearing pass.
// A held result does not block the next request; only the hand-over of a
// second result waits until the first is taken.
`default_nettype none

module ordered_list_append_delete_search_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic [5:0]              o_position,
    output logic [6:0]              o_entry_count
);
    import olads_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Request sequencer.
    olads_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Entry store, walk and result registers.
    olads_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

### sv/olads_ctrl.sv
// ----------------------------------------------------------------------------
// olads_ctrl: request sequencer for the ordered list unit
// Accepts one request at a time, steps the datapath through the walk and
// the shift, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module olads_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire olads_pkg::t_stat i_stat,
    output olads_pkg::t_cmd     o_cmd
);
    import olads_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.res_we = 1'b1;
                    n_state      = S_FINISH;
                    unique case (i_stat.in_kind) inside
                        KIND_APPEND: begin
                            if (i_stat.list_full) begin
                                o_cmd.res_status = ST_FULL;
                            end else begin
                                o_cmd.append_wr  = 1'b1;
                                o_cmd.res_status = ST_DONE;
                            end
                        end
                        KIND_DELETE, KIND_SEARCH: begin
                            if (i_stat.list_empty) begin
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.res_we     = 1'b0;
                                o_cmd.scan_start = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end
                        default: begin
                            o_cmd.res_status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.res_we       = 1'b1;
                    o_cmd.res_status   = ST_DONE;
                    o_cmd.res_take_idx = 1'b1;
                    n_state            = i_stat.is_delete ? S_SHIFT : S_FINISH;
                end else if (i_stat.miss_end) begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_FINISH;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_end) begin
                    o_cmd.del_commit = 1'b1;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### sv/olads_datapath.sv
// ----------------------------------------------------------------------------
// olads_datapath: entry store and walk logic for the ordered list unit
// Holds the entries in a single-port-write, single-port-read memory, walks
// them one per cycle to find a match, closes the gap after a delete and
// keeps the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module olads_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [31:0] i_value,
    input  wire olads_pkg::t_cmd    i_cmd,
    output olads_pkg::t_stat        o_stat,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic [5:0]              o_position,
    output logic [6:0]              o_entry_count
);
    import olads_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [31:0]    r_mem [CAPACITY];
    logic [31:0]    r_rd_data;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_ptr;
    logic [AW-1:0]  r_rd_idx;
    logic           r_rd_vld;
    logic [31:0]    r_value;
    logic           r_is_delete;
    t_status        r_res_status;
    logic [5:0]     r_res_pos;
    logic           r_out_vld;
    logic [1:0]     r_out_status;
    logic [5:0]     r_out_pos;
    logic [6:0]     r_out_count;

    logic           rd_en;
    logic           match;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [31:0]    wr_data;

    // A read is issued while the walk pointer is below the count.
    assign rd_en = (i_cmd.scan_step || i_cmd.shift_step) && (r_ptr < r_count);
    assign match = (r_rd_data == r_value);

    // Writes come from an append at the tail or from the gap-closing shift.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = i_value;
        if (i_cmd.append_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_step && r_rd_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_idx - AW'(1);
            wr_data = r_rd_data;
        end
    end

    // Entry memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr[AW-1:0]];
        end
    end

    // Count, walk pointer and read tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.append_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.del_commit) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_ptr    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step || i_cmd.shift_step) begin
                r_rd_vld <= rd_en;
                if (rd_en) begin
                    r_ptr <= r_ptr + CW'(1);
                end
            end
        end
    end

    // Request capture and read index tag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value     <= i_value;
            r_is_delete <= (i_kind == KIND_DELETE);
        end
        if (rd_en) begin
            r_rd_idx <= r_ptr[AW-1:0];
        end
        if (i_cmd.res_we) begin
            r_res_status <= i_cmd.res_status;
            r_res_pos    <= i_cmd.res_take_idx ? 6'(r_rd_idx) : 6'd0;
        end
    end

    // Output register; a result waits here until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_pos    <= r_res_pos;
            r_out_count  <= 7'(r_count);
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.in_kind    = i_kind;
        o_stat.is_delete  = r_is_delete;
        o_stat.list_empty = (r_count == '0);
        o_stat.list_full  = (r_count >= CAP_C);
        o_stat.hit        = r_rd_vld && match;
        o_stat.miss_end   = r_rd_vld && !match && (r_ptr >= r_count);
        o_stat.shift_end  = (r_ptr >= r_count);
        o_stat.out_free   = !r_out_vld || i_ready;
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_out_status;
    assign o_position    = r_out_pos;
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire
